### hdl/rcgc_pkg.sv
// Package for the refcounted clock gate controller: command codes, domain
// indexes, gate bit tables and the result structs shared between modules.
// No dependencies.
package rcgc_pkg;

	localparam int unsigned DOMAINS   = 11;
	localparam int unsigned CNT_W     = 16;
	localparam logic [3:0]  DOM_POWER = 4'd10;
	localparam logic [3:0]  DOM_LAST  = 4'd9;

	localparam logic [2:0] CMD_ENABLE  = 3'd0;
	localparam logic [2:0] CMD_DISABLE = 3'd1;
	localparam logic [2:0] CMD_PWR_ON  = 3'd2;
	localparam logic [2:0] CMD_PWR_OFF = 3'd3;
	localparam logic [2:0] CMD_SETRATE = 3'd4;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_BAD_CLNT = 2'd1;
	localparam logic [1:0] STS_BAD_RATE = 2'd2;

	localparam logic [3:0] DOM_ISP2X   = 4'd0;
	localparam logic [3:0] DOM_OFFLINE = 4'd1;
	localparam logic [3:0] DOM_PHY     = 4'd2;
	localparam logic [3:0] DOM_IFACE   = 4'd3;
	localparam logic [3:0] DOM_OFFAXI  = 4'd4;
	localparam logic [3:0] DOM_LCD_CI  = 4'd5;
	localparam logic [3:0] DOM_LCD_AHB = 4'd6;
	localparam logic [3:0] DOM_LCD_SCK = 4'd7;
	localparam logic [3:0] DOM_LCD_AXI = 4'd8;
	localparam logic [3:0] DOM_JPEG    = 4'd9;

	// power gate bits live in the low register
	localparam logic [31:0] PWR_LOW_BITS  = 32'h0007_0002;
	// default rates programmed by the first power on
	localparam logic [31:0] PWR_HIGH_MASK = (32'h1F << 17) | (32'h1F << 25) | 32'h0000_3C80;
	localparam logic [31:0] PWR_HIGH_VAL  = 32'h0008_0000 | 32'h0A00_0000 | 32'h0000_0080;

	localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [CNT_W-1:0] new_c;
		logic [CNT_W-1:0] new_t;
		logic             c_sat;
		logic             t_sat;
	} cnt_res_t;

	typedef struct packed {
		logic        ok;
		logic        hi_sel;
		logic [31:0] mask;
		logic [31:0] val;
	} rate_res_t;

	// 1 selects the high register (0x50), 0 the low register (0x4C)
	function automatic logic gate_hi(input logic [3:0] dom);
		logic r;
		r = 1'b1;
		if (dom == DOM_LCD_AHB || dom == DOM_LCD_SCK || dom == DOM_LCD_AXI)
			r = 1'b0;
		return r;
	endfunction

	function automatic logic [31:0] gate_mask(input logic [3:0] dom);
		logic [31:0] m;
		unique case (dom)
			DOM_ISP2X:   m = 32'h0081_0000;
			DOM_OFFLINE: m = 32'h8100_0000;
			DOM_PHY:     m = 32'h0000_0024;
			DOM_IFACE:   m = 32'h0000_0009;
			DOM_OFFAXI:  m = 32'h0000_0300;
			DOM_LCD_CI:  m = 32'h0000_0012;
			DOM_LCD_AHB: m = 32'h0000_0024;
			DOM_LCD_SCK: m = 32'h0000_0010;
			DOM_LCD_AXI: m = 32'h0000_0009;
			DOM_JPEG:    m = 32'h0000_C000;
			default:     m = 32'h0;
		endcase
		return m;
	endfunction

endpackage

### hdl/rcgc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rcgc_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 44
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/rcgc_count_unit.sv
// Shared saturating up/down step for one client counter and one total counter.
// Depends on rcgc_pkg.
module rcgc_count_unit (
	input  logic [15:0]        cnt,
	input  logic [15:0]        tot,
	input  logic               up,
	output rcgc_pkg::cnt_res_t res
);
	import rcgc_pkg::*;

	always_comb begin
		res = '0;
		if (up) begin
			res.c_sat = (cnt == CNT_MAX);
			res.t_sat = (tot == CNT_MAX);
			res.new_c = res.c_sat ? cnt : cnt + 16'd1;
			res.new_t = res.t_sat ? tot : tot + 16'd1;
		end else begin
			res.c_sat = (cnt == '0);
			res.t_sat = (tot == '0);
			res.new_c = res.c_sat ? cnt : cnt - 16'd1;
			res.new_t = res.t_sat ? tot : tot - 16'd1;
		end
	end

endmodule

### hdl/rcgc_rate_map.sv
// Maps a requested rate for one domain to mux and divider bits of a register.
// Depends on rcgc_pkg.
module rcgc_rate_map (
	input  logic [3:0]          dom,
	input  logic [18:0]         rate,
	output rcgc_pkg::rate_res_t res
);
	import rcgc_pkg::*;

	always_comb begin
		res.ok     = 1'b1;
		res.hi_sel = 1'b1;
		res.mask   = '0;
		res.val    = '0;
		unique case (dom)
			DOM_ISP2X: begin
				res.mask = 32'h1F << 17;
				priority if (rate == 19'd624) res.val = '0;
				else if (rate == 19'd312) res.val = 32'h0008_0000;
				else if (rate == 19'd416) res.val = 32'h0002_0000;
				else if (rate == 19'd208) res.val = 32'h000A_0000;
				else res.ok = 1'b0;
			end
			DOM_OFFLINE: begin
				res.mask = 32'h1F << 25;
				priority if (rate == 19'd416) res.val = '0;
				else if (rate == 19'd208) res.val = 32'h0800_0000;
				else if (rate == 19'd624) res.val = 32'h0200_0000;
				else if (rate == 19'd312) res.val = 32'h0A00_0000;
				else res.ok = 1'b0;
			end
			DOM_PHY: begin
				res.mask = 32'h0000_0080;
				priority if (rate == 19'd52) res.val = 32'h0000_0080;
				else if (rate == 19'd104) res.val = '0;
				else res.ok = 1'b0;
			end
			DOM_LCD_CI: begin
				res.mask = 32'h0000_0C00;
				priority if (rate == 19'd312) res.val = '0;
				else if (rate == 19'd208) res.val = 32'h0000_0400;
				else if (rate == 19'd156) res.val = 32'h0000_0800;
				else if (rate == 19'd350) res.val = 32'h0000_0C00;
				else res.ok = 1'b0;
			end
			DOM_LCD_SCK: begin
				res.hi_sel = 1'b0;
				res.mask   = 32'h0000_0040 | (32'h1F << 10) | 32'h0000_0300;
				priority if (rate == 19'd312000) res.val = 32'h0000_0100;
				else if (rate == 19'd125000) res.val = (32'd2 << 10) | 32'h0000_0200;
				else if (rate == 19'd104000) res.val = (32'd3 << 10) | 32'h0000_0200;
				else if (rate == 19'd62400) res.val = (32'd5 << 10) | 32'h0000_0200;
				else if (rate == 19'd52000) res.val = 32'h0000_0140;
				else res.ok = 1'b0;
			end
			DOM_JPEG: begin
				res.mask = 32'h0000_3000;
				priority if (rate == 19'd312) res.val = '0;
				else if (rate == 19'd208) res.val = 32'h0000_1000;
				else if (rate == 19'd156) res.val = 32'h0000_2000;
				else if (rate == 19'd350) res.val = 32'h0000_3000;
				else res.ok = 1'b0;
			end
			default: begin
				res.ok = 1'b1;
			end
		endcase
	end

endmodule

### hdl/refcounted_clock_gate_controller_unit.sv
// Top level of the refcounted clock and power gate controller.
// Depends on rcgc_pkg, rcgc_ram, rcgc_count_unit and rcgc_rate_map.
//
// Usage: one command beat enters on the in_valid/in_ready channel (cmd,
// clock_mask, client_id, rate); one result beat leaves on out_valid/out_ready
// with both register images, the saturation flags and a status code.
// A small sequencer walks the domains one at a time. Enable and disable give
// a selected domain a read state (the client counter RAM read) and an update
// state (the shared counter step and write back), an unselected one the read
// state only; a finish state loads the result. Power on/off do both for the
// power domain, set rate takes one domain per cycle through the rate mapper,
// a bad client or unused command goes straight to finish. in_ready is high
// only while the sequencer is idle, so one command is in work at a time.
// The result sits in an output register; the next command is accepted while
// it waits, and the sequencer holds its finished result until the output
// register frees up.
// Reset clears all counters (client counters through per-entry valid bits),
// both register images and the handshakes; no clearing pass is needed.
module refcounted_clock_gate_controller_unit #(
	parameter int unsigned CLIENTS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  cmd,
	input  logic [9:0]  clock_mask,
	input  logic [2:0]  client_id,
	input  logic [18:0] rate,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] ctrl_low_image,
	output logic [31:0] ctrl_high_image,
	output logic [10:0] client_errors,
	output logic [10:0] total_errors,
	output logic [1:0]  status
);
	import rcgc_pkg::*;

	localparam int unsigned DEPTH = CLIENTS * DOMAINS;
	localparam int unsigned AW    = $clog2(DEPTH);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_RATE = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]       state_q;
	logic [2:0]       cmd_q;
	logic [9:0]       mask_q;
	logic [2:0]       client_q;
	logic [18:0]      rate_q;
	logic [3:0]       dom_q;
	logic [31:0]      low_q;
	logic [31:0]      high_q;
	logic [10:0]      cerr_q;
	logic [10:0]      terr_q;
	logic [1:0]       sts_q;
	logic [15:0]      total_q [DOMAINS];
	logic [DEPTH-1:0] cvalid_q;
	logic             out_valid_q;

	logic [AW-1:0]    addr;
	logic [15:0]      rdata;
	logic [15:0]      cnt_cur;
	logic             up;
	logic             sel;
	logic             last;
	logic [10:0]      ext_mask;
	logic [10:0]      dom_oh;
	logic [31:0]      gmask;
	logic             ghi;
	logic             fin_go;
	logic             bad_client;
	cnt_res_t         cres;
	rate_res_t        rres;
	logic [31:0]      low_n;
	logic [31:0]      high_n;

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign bad_client = ({1'b0, client_id} >= 4'(CLIENTS));

	assign addr     = AW'(client_q) * AW'(DOMAINS) + AW'(dom_q);
	assign ext_mask = {1'b1, mask_q};
	assign sel      = ext_mask[dom_q];
	assign last     = (dom_q == DOM_POWER) || (dom_q == DOM_LAST);
	assign dom_oh   = 11'd1 << dom_q;
	assign cnt_cur  = cvalid_q[addr] ? rdata : '0;
	assign up       = (cmd_q == CMD_ENABLE) || (cmd_q == CMD_PWR_ON);
	assign gmask    = gate_mask(dom_q);
	assign ghi      = gate_hi(dom_q);
	assign fin_go   = !out_valid_q || out_ready;

	rcgc_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_cnt_ram (
		.clk   (clk),
		.we    (state_q == ST_UPD),
		.waddr (addr),
		.wdata (cres.new_c),
		.raddr (addr),
		.rdata (rdata)
	);

	rcgc_count_unit u_count (
		.cnt (cnt_cur),
		.tot (total_q[dom_q]),
		.up  (up),
		.res (cres)
	);

	rcgc_rate_map u_rate (
		.dom  (dom_q),
		.rate (rate_q),
		.res  (rres)
	);

	// next register images for the update and rate states
	always_comb begin
		low_n  = low_q;
		high_n = high_q;
		if (state_q == ST_UPD) begin
			if (dom_q == DOM_POWER) begin
				if (up && cres.new_t == 16'd1) begin
					low_n  = low_q | PWR_LOW_BITS;
					high_n = (high_q & ~PWR_HIGH_MASK) | PWR_HIGH_VAL;
				end else if (!up && cres.new_t == '0) begin
					low_n = low_q & ~PWR_LOW_BITS;
				end
			end else if (up && cres.new_t == 16'd1) begin
				if (ghi) high_n = high_q | gmask;
				else low_n = low_q | gmask;
			end else if (!up && cres.new_t == '0) begin
				if (ghi) high_n = high_q & ~gmask;
				else low_n = low_q & ~gmask;
			end
		end else if (state_q == ST_RATE && sel && rres.ok) begin
			if (rres.hi_sel) high_n = (high_q & ~rres.mask) | (rres.val & rres.mask);
			else low_n = (low_q & ~rres.mask) | (rres.val & rres.mask);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dom_q       <= '0;
			low_q       <= '0;
			high_q      <= '0;
			cvalid_q    <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < DOMAINS; i++) begin
				total_q[i] <= '0;
			end
		end else begin
			low_q  <= low_n;
			high_q <= high_n;
			// load a finished result, or drop the beat once taken
			if (state_q == ST_FIN && fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (cmd <= CMD_PWR_OFF && bad_client) begin
							state_q <= ST_FIN;
						end else if (cmd == CMD_ENABLE || cmd == CMD_DISABLE) begin
							dom_q   <= '0;
							state_q <= ST_RD;
						end else if (cmd == CMD_PWR_ON || cmd == CMD_PWR_OFF) begin
							dom_q   <= DOM_POWER;
							state_q <= ST_RD;
						end else if (cmd == CMD_SETRATE) begin
							dom_q   <= '0;
							state_q <= ST_RATE;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_RD: begin
					// skip unselected domains; the RAM read is issued here
					if (sel) begin
						state_q <= ST_UPD;
					end else if (last) begin
						state_q <= ST_FIN;
					end else begin
						dom_q <= dom_q + 4'd1;
					end
				end
				ST_UPD: begin
					cvalid_q[addr] <= 1'b1;
					total_q[dom_q] <= cres.new_t;
					if (last) begin
						state_q <= ST_FIN;
					end else begin
						dom_q   <= dom_q + 4'd1;
						state_q <= ST_RD;
					end
				end
				ST_RATE: begin
					if (last) begin
						state_q <= ST_FIN;
					end else begin
						dom_q <= dom_q + 4'd1;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload: command fields, flags and the result beat
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			cmd_q    <= cmd;
			mask_q   <= clock_mask;
			client_q <= client_id;
			rate_q   <= rate;
			cerr_q   <= '0;
			terr_q   <= '0;
			sts_q    <= (cmd <= CMD_PWR_OFF && bad_client) ? STS_BAD_CLNT : STS_OK;
		end else if (state_q == ST_UPD) begin
			cerr_q <= cerr_q | (cres.c_sat ? dom_oh : '0);
			terr_q <= terr_q | (cres.t_sat ? dom_oh : '0);
		end else if (state_q == ST_RATE && sel && !rres.ok) begin
			sts_q <= STS_BAD_RATE;
		end
		if (state_q == ST_FIN && fin_go) begin
			ctrl_low_image  <= low_q;
			ctrl_high_image <= high_q;
			client_errors   <= cerr_q;
			total_errors    <= terr_q;
			status          <= sts_q;
		end
	end

endmodule

### hdl/rcgc_checker.sv
// Port-level checker for the refcounted clock gate controller, with its bind.
// Depends on refcounted_clock_gate_controller_unit.
module rcgc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] ctrl_low_image,
	input logic [10:0] client_errors,
	input logic [10:0] total_errors,
	input logic [1:0]  status
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ctrl_low_image) && $stable(status))
		else $error("result beat changed while stalled");

	// one command in work at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready right after accepting a beat");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status != 2'd3)
		else $error("undefined status code");

	// bad-client and bad-rate beats never touch counters, so carry no error flags
	a_no_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == 2'd1 || status == 2'd2) |->
		client_errors == '0 && total_errors == '0)
		else $error("error flags set on an ignored beat");

endmodule

bind refcounted_clock_gate_controller_unit rcgc_checker u_rcgc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.ctrl_low_image (ctrl_low_image),
	.client_errors  (client_errors),
	.total_errors   (total_errors),
	.status         (status)
);
